### rtl/core/ddc_pkg.sv
// Shared types, port codes and tables for the cascaded DMA controller pair.
package ddc_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [2:0] CH_NONE = 3'd4;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_REQ   = 2'd2;
    localparam logic [1:0] MODE_SVC   = 2'd3;

    localparam logic [2:0] FLT_OK       = 3'd0;
    localparam logic [2:0] FLT_WIDTH    = 3'd1;
    localparam logic [2:0] FLT_BOUNDARY = 3'd2;
    localparam logic [2:0] FLT_BLOCK    = 3'd3;
    localparam logic [2:0] FLT_TTYPE3   = 3'd4;
    localparam logic [2:0] FLT_PORT     = 3'd5;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_VERIFY = 2'd3;

    localparam logic [7:0] P_STATUS0 = 8'h08, P_STATUS1 = 8'hd0;
    localparam logic [7:0] P_REQ0    = 8'h09, P_REQ1    = 8'hd2;
    localparam logic [7:0] P_SMASK0  = 8'h0a, P_SMASK1  = 8'hd4;
    localparam logic [7:0] P_MODE0   = 8'h0b, P_MODE1   = 8'hd6;
    localparam logic [7:0] P_CLRFF0  = 8'h0c, P_CLRFF1  = 8'hd8;
    localparam logic [7:0] P_MCLR0   = 8'h0d, P_MCLR1   = 8'hda;
    localparam logic [7:0] P_CLRM0   = 8'h0e, P_CLRM1   = 8'hdc;
    localparam logic [7:0] P_WMASK0  = 8'h0f, P_WMASK1  = 8'hde;
    localparam logic [7:0] P_PAGE_NONE = 8'h80;

    typedef enum logic [2:0] {
        OP_READ,
        OP_WRITE,
        OP_WRITE_MODE2,
        OP_REQ,
        OP_SVC,
        OP_BAD_READ,
        OP_BAD_WRITE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  port;
        logic [15:0] data;
        logic [2:0]  req_chan;
        logic        req_level;
    } item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        hold_request;
        logic [1:0]  xfer_kind;
        logic [23:0] xfer_address;
        logic [2:0]  xfer_channel;
        logic        word_transfer;
        logic        terminal_count;
        logic [2:0]  fault;
    } result_t;

    // Page register port low bits to channel; CH_NONE marks unused ports.
    function automatic logic [2:0] page_chan(input logic [2:0] p);
        logic [2:0] r;
        unique case (p)
            3'd1:    r = 3'd2;
            3'd2:    r = 3'd3;
            3'd3:    r = 3'd1;
            3'd7:    r = 3'd0;
            default: r = CH_NONE;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/dual_dma_controller.sv
// Top level of the cascaded pair of 8237-style DMA controllers.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata[31:0], s_tuser[1:0] = access mode
//  m_       out  m_tvalid/m_tready  m_tdata[47:0], m_tuser[1:0] = transfer kind
//
// Every request produces exactly one result; a new request is taken every cycle
// unless the queue is full. The front end classifies requests into a short queue;
// the back end executes one queued request per cycle, unless a held result stalls
// it, against the register file into the result register that drives m_tvalid.
// Reset (aresetn low, synchronous) masks all channels, clears all but queue/result data.
// A stalled m_tready holds the result; the queue absorbs up to QUEUE_DEPTH more.
module dual_dma_controller
    import ddc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // port[7:0], write_byte[23:8], access_size[26:24], request_channel[29:27],
    // request_level[30], zero[31]
    input  logic [31:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], hold_request[8], xfer_address[32:9], xfer_channel[35:33],
    // word_transfer[36], terminal_count[37], fault[40:38], zero[47:41]
    output logic [47:0] m_tdata,
    // xfer_kind[1:0]
    output logic [1:0]  m_tuser
);

    logic    q_full, q_push, q_pop, q_valid;
    item_t   push_item, head_item;
    result_t res;

    // Classify each request as it arrives.
    ddc_front u_front (
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    // Decouple acceptance from execution.
    ddc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (head_item)
    );

    // Execute against controller state and hold the result.
    ddc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (head_item),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tuser = res.xfer_kind;
    assign m_tdata = {7'd0, res.fault, res.terminal_count, res.word_transfer,
                      res.xfer_channel, res.xfer_address, res.hold_request,
                      res.read_data};

endmodule

### rtl/core/ddc_front.sv
// Front end: accept requests and classify them by access kind and width.
module ddc_front
    import ddc_pkg::*;
(
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        q_full,
    output logic        q_push,
    output item_t       q_item
);

    logic [7:0] port_w;
    logic [2:0] size_w;

    assign port_w   = s_tdata[7:0];
    assign size_w   = s_tdata[26:24];
    assign s_tready = !q_full && aresetn;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        q_item.port      = port_w;
        q_item.data      = s_tdata[23:8];
        q_item.req_chan  = s_tdata[29:27];
        q_item.req_level = s_tdata[30];
        unique case (s_tuser)
            MODE_READ:  q_item.op = (size_w == 3'd1) ? OP_READ : OP_BAD_READ;
            MODE_WRITE: begin
                if (size_w == 3'd1)
                    q_item.op = OP_WRITE;
                else if (size_w == 3'd2 && port_w == P_MODE0)
                    q_item.op = OP_WRITE_MODE2;
                else
                    q_item.op = OP_BAD_WRITE;
            end
            MODE_REQ:   q_item.op = OP_REQ;
            default:    q_item.op = OP_SVC;
        endcase
    end

endmodule

### rtl/core/ddc_queue.sv
// Short request queue between the front and back ends.
module ddc_queue
    import ddc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  valid,
    output item_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t          slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign valid = (cnt_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### rtl/core/ddc_back.sv
// Back end: controller register file, service cycles and the result register.
module ddc_back
    import ddc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     q_valid,
    input  item_t    q_item,
    output logic     q_pop,
    output logic     out_valid,
    input  logic     out_ready,
    output result_t  out_res
);

    logic        tg_reg [2], tg_next [2];
    logic [7:0]  st_reg [2], st_next [2];
    logic [3:0]  mk_reg [2], mk_next [2];
    logic [15:0] ba_reg [8], ba_next [8];
    logic [15:0] ca_reg [8], ca_next [8];
    logic [15:0] bc_reg [8], bc_next [8];
    logic [15:0] cc_reg [8], cc_next [8];
    logic [7:0]  pg_reg [8], pg_next [8];
    logic [5:0]  md_reg [8], md_next [8];
    logic        hold_reg, hold_next;

    logic        ov_reg;
    result_t     res_reg, res_next;

    function automatic logic [2:0] pick(input logic [7:0] st, input logic [3:0] mk);
        logic [2:0] r;
        r = CH_NONE;
        for (int k = 3; k >= 0; k--) begin
            if (st[4+k] && !mk[k])
                r = 3'(k);
        end
        return r;
    endfunction

    // Fault raised by a rising request line: block mode first, then boundary.
    function automatic logic [2:0] raise_check(input logic [5:0] md, input logic [7:0] pg,
                                               input logic [15:0] ba, input logic [15:0] bc,
                                               input logic c);
        logic [31:0] lo, hi, span, msk;
        logic [2:0]  f;
        lo   = {8'd0, pg, 16'd0} | (c ? {15'd0, ba, 1'b0} : {16'd0, ba});
        span = c ? {15'd0, bc, 1'b0} : {16'd0, bc};
        hi   = md[3] ? lo - span : lo + span;
        msk  = c ? 32'hfffe0000 : 32'h7fff0000;
        f    = FLT_OK;
        if (md[5:4] == 2'd2)
            f = FLT_BLOCK;
        else if (((lo ^ hi) & msk) != '0)
            f = FLT_BOUNDARY;
        return f;
    endfunction

    assign q_pop     = q_valid && (!ov_reg || out_ready);
    assign out_valid = ov_reg;
    assign out_res   = res_reg;

    always_comb begin : exec
        logic [7:0]  p, v;
        logic [2:0]  f, pch, sch, idx;
        logic        c, cnt, is_reg, run0, run1, tc;
        logic [15:0] w;
        logic [1:0]  ch;

        tg_next = tg_reg; st_next = st_reg; mk_next = mk_reg;
        ba_next = ba_reg; ca_next = ca_reg; bc_next = bc_reg; cc_next = cc_reg;
        pg_next = pg_reg; md_next = md_reg; hold_next = hold_reg;
        res_next = '0;
        p = q_item.port; v = q_item.data[7:0];
        f = FLT_OK; run0 = 1'b0; run1 = 1'b0; tc = 1'b0;
        c = 1'b0; cnt = 1'b0; ch = 2'd0; is_reg = 1'b0; idx = 3'd0; w = '0;
        pch = CH_NONE; sch = CH_NONE;

        // Address and count register decode.
        if (p < 8'd8) begin
            is_reg = 1'b1; c = 1'b0; ch = p[2:1]; cnt = p[0];
        end else if (p >= 8'hc0 && p <= 8'hcf && !p[0]) begin
            is_reg = 1'b1; c = 1'b1; ch = p[3:2]; cnt = p[1];
        end

        unique case (q_item.op)
            OP_BAD_READ: begin
                res_next.read_data = 8'hff;
                f = FLT_WIDTH;
            end
            OP_BAD_WRITE: f = FLT_WIDTH;
            OP_READ: begin
                if (is_reg) begin
                    idx = {c, ch};
                    w = cnt ? cc_reg[idx] : ca_reg[idx];
                    res_next.read_data = tg_reg[c] ? w[15:8] : w[7:0];
                    tg_next[c] = !tg_reg[c];
                end else if (p[7:4] == 4'h8 && p != P_PAGE_NONE) begin
                    pch = page_chan(p[2:0]);
                    if (pch != CH_NONE)
                        res_next.read_data = pg_reg[{p[3], pch[1:0]}];
                end else begin
                    priority case (p)
                        P_STATUS0, P_STATUS1: begin
                            c = (p == P_STATUS1);
                            res_next.read_data = st_reg[c];
                            st_next[c] = {st_reg[c][7:4], 4'h0};
                        end
                        P_MCLR0, P_MCLR1, P_REQ1, P_SMASK1, P_MODE1,
                        P_CLRFF1, P_CLRM1, P_WMASK1: ;
                        default: f = FLT_PORT;
                    endcase
                end
            end
            OP_WRITE, OP_WRITE_MODE2: begin
                if (is_reg) begin
                    idx = {c, ch};
                    if (cnt) begin
                        if (tg_reg[c]) begin
                            bc_next[idx][15:8] = v; cc_next[idx][15:8] = v;
                        end else begin
                            bc_next[idx][7:0] = v; cc_next[idx][7:0] = v;
                        end
                    end else begin
                        if (tg_reg[c]) begin
                            ba_next[idx][15:8] = v; ca_next[idx][15:8] = v;
                        end else begin
                            ba_next[idx][7:0] = v; ca_next[idx][7:0] = v;
                        end
                    end
                    tg_next[c] = !tg_reg[c];
                end else if (p[7:4] == 4'h8 && p != P_PAGE_NONE) begin
                    pch = page_chan(p[2:0]);
                    if (pch != CH_NONE)
                        pg_next[{p[3], pch[1:0]}] = v;
                end else begin
                    c = (p >= 8'hc0);
                    ch = v[1:0];
                    priority case (p)
                        P_STATUS0, P_STATUS1: ;
                        P_REQ0, P_REQ1: begin
                            st_next[c][4+ch] = v[2];
                            run0 = !c; run1 = c;
                        end
                        P_SMASK0, P_SMASK1: begin
                            mk_next[c][ch] = v[2];
                            run0 = !c; run1 = c;
                        end
                        P_MODE0, P_MODE1: md_next[{c, ch}] = v[7:2];
                        P_CLRFF0, P_CLRFF1: tg_next[c] = 1'b0;
                        P_MCLR0, P_MCLR1: begin
                            mk_next[c] = 4'hf; st_next[c] = 8'h00; tg_next[c] = 1'b0;
                        end
                        P_CLRM0, P_CLRM1: begin
                            mk_next[c] = 4'h0;
                            run0 = !c; run1 = c;
                        end
                        P_WMASK0, P_WMASK1: begin
                            mk_next[c] = v[3:0];
                            run0 = !c; run1 = c;
                        end
                        default: f = FLT_PORT;
                    endcase
                    // Second byte of a word mode write lands on clear toggle.
                    if (q_item.op == OP_WRITE_MODE2)
                        tg_next[0] = 1'b0;
                end
            end
            OP_REQ: begin
                c = q_item.req_chan[2]; ch = q_item.req_chan[1:0];
                idx = q_item.req_chan;
                st_next[c][4+ch] = q_item.req_level;
                if (q_item.req_level)
                    f = raise_check(md_reg[idx], pg_reg[idx], ba_reg[idx], bc_reg[idx], c);
                run0 = !c; run1 = c;
            end
            default: begin
                // Service cycle: controller 1 first, channel 4 defers to controller 0.
                c = 1'b1;
                sch = pick(st_reg[1], mk_reg[1]);
                if (sch == 3'd0) begin
                    c = 1'b0;
                    sch = pick(st_reg[0], mk_reg[0]);
                end
                if (sch != CH_NONE) begin
                    idx = {c, sch[1:0]};
                    // Word channels shift the address; bit 16 overlaps the page.
                    res_next.xfer_address = {pg_reg[idx], 16'd0} |
                        (c ? {7'd0, ca_reg[idx], 1'b0} : {8'd0, ca_reg[idx]});
                    ca_next[idx] = md_reg[idx][3] ? ca_reg[idx] - 1'b1 : ca_reg[idx] + 1'b1;
                    cc_next[idx] = cc_reg[idx] - 1'b1;
                    if (cc_reg[idx] == 16'h0000) begin
                        tc = 1'b1;
                        st_next[c][sch[1:0]] = 1'b1;
                        if (md_reg[idx][2]) begin
                            ca_next[idx] = ba_reg[idx];
                            cc_next[idx] = bc_reg[idx];
                        end else begin
                            mk_next[c][sch[1:0]] = 1'b1;
                        end
                    end
                    unique case (md_reg[idx][1:0])
                        2'd1:    res_next.xfer_kind = KIND_WRITE;
                        2'd2:    res_next.xfer_kind = KIND_READ;
                        2'd0:    res_next.xfer_kind = KIND_VERIFY;
                        default: f = FLT_TTYPE3;
                    endcase
                    res_next.xfer_channel   = idx;
                    res_next.word_transfer  = c;
                    res_next.terminal_count = tc;
                    if (tc) begin
                        hold_next = 1'b0;
                        if (!c) begin
                            st_next[1][4] = 1'b0;
                            run1 = 1'b1;
                        end
                    end
                end
            end
        endcase

        // Cascade: controller 0 output drives request line 4.
        if (run0) begin
            if (st_next[0][7:4] == 4'h0) begin
                st_next[1][4] = 1'b0;
                run1 = 1'b1;
            end else if (pick(st_next[0], mk_next[0]) != CH_NONE) begin
                st_next[1][4] = 1'b1;
                if (f == FLT_OK)
                    f = raise_check(md_next[4], pg_next[4], ba_next[4], bc_next[4], 1'b1);
                run1 = 1'b1;
            end
        end
        if (run1) begin
            if (st_next[1][7:4] == 4'h0)
                hold_next = 1'b0;
            else if (pick(st_next[1], mk_next[1]) != CH_NONE)
                hold_next = 1'b1;
        end

        res_next.hold_request = hold_next;
        res_next.fault        = f;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 2; k++) begin
                tg_reg[k] <= 1'b0;
                st_reg[k] <= 8'h00;
                mk_reg[k] <= 4'hf;
            end
            for (int k = 0; k < 8; k++) begin
                ba_reg[k] <= '0; ca_reg[k] <= '0; bc_reg[k] <= '0; cc_reg[k] <= '0;
                pg_reg[k] <= '0; md_reg[k] <= '0;
            end
            hold_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end else begin
            if (q_pop) begin
                tg_reg <= tg_next; st_reg <= st_next; mk_reg <= mk_next;
                ba_reg <= ba_next; ca_reg <= ca_next; bc_reg <= bc_next; cc_reg <= cc_next;
                pg_reg <= pg_next; md_reg <= md_next; hold_reg <= hold_next;
                ov_reg <= 1'b1;
            end else if (out_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop)
            res_reg <= res_next;
    end

endmodule

### tb/testbench.sv
// Self-checking testbench for the cascaded DMA controller pair.
`timescale 1ns / 1ps

module testbench;
    import ddc_pkg::*;

    localparam int HALF_PERIOD = 6;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    dual_dma_controller dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Predictor state of both controllers.
    logic        tgl [2];
    logic [7:0]  stat [2];
    logic [3:0]  msk [2];
    logic [15:0] b_addr [8];
    logic [15:0] c_addr [8];
    logic [15:0] b_cnt [8];
    logic [15:0] c_cnt [8];
    logic [7:0]  page [8];
    logic [5:0]  cmode [8];
    logic        hold;
    logic [2:0]  flt_now;

    result_t     pending_results [$];
    int          error_count = 0;
    int          hold_off = 0;
    bit          stim_done = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic void note_fault(input logic [2:0] f);
        if (flt_now == FLT_OK) flt_now = f;
    endfunction

    function automatic int lowest_ready(input int c);
        for (int ch = 0; ch < 4; ch++)
            if (stat[c][4+ch] && !msk[c][ch]) return ch;
        return 4;
    endfunction

    // Controller 0 output feeds request line 4; controller 1 output drives hold.
    function automatic void drive_line(input int chan, input bit level);
        int c, ch, i;
        logic [31:0] lo, hi, span, m;
        c = (chan >> 2) & 1;
        ch = chan & 3;
        i = c * 4 + ch;
        if (!level) begin
            stat[c][4+ch] = 1'b0;
        end else begin
            stat[c][4+ch] = 1'b1;
            if (cmode[i][5:4] == 2'd2) note_fault(FLT_BLOCK);
            lo = ({24'd0, page[i]} << 16) | ({16'd0, b_addr[i]} << c);
            span = {16'd0, b_cnt[i]} << c;
            hi = cmode[i][3] ? lo - span : lo + span;
            m = c ? 32'hfffe0000 : 32'h7fff0000;
            if (((lo ^ hi) & m) != 0) note_fault(FLT_BOUNDARY);
        end
        refresh_out(c);
    endfunction

    function automatic void refresh_out(input int c);
        if (stat[c][7:4] == 4'd0) begin
            if (c) hold = 1'b0; else drive_line(4, 1'b0);
        end else if (lowest_ready(c) < 4) begin
            if (c) hold = 1'b1; else drive_line(4, 1'b1);
        end
    endfunction

    function automatic bit decode_reg(input logic [7:0] p, output int c, output int ch,
                                      output bit is_cnt);
        c = 0; ch = 0; is_cnt = 0;
        if (p < 8) begin
            ch = p[2:1]; is_cnt = p[0]; return 1;
        end
        if (p >= 8'hc0 && p <= 8'hcf && !p[0]) begin
            c = 1; ch = p[3:2]; is_cnt = p[1]; return 1;
        end
        return 0;
    endfunction

    function automatic int page_index(input logic [7:0] p);
        case (p[2:0])
            3'd1: return p[3] * 4 + 2;
            3'd2: return p[3] * 4 + 3;
            3'd3: return p[3] * 4 + 1;
            3'd7: return p[3] * 4;
            default: return -1;
        endcase
    endfunction

    function automatic logic [7:0] read_port(input logic [7:0] p);
        int c, ch, i;
        bit is_cnt;
        logic [15:0] v;
        if (decode_reg(p, c, ch, is_cnt)) begin
            i = c * 4 + ch;
            v = is_cnt ? c_cnt[i] : c_addr[i];
            if (tgl[c]) v = v >> 8;
            tgl[c] = ~tgl[c];
            return v[7:0];
        end
        if (p[7:4] == 4'h8 && p != P_PAGE_NONE) begin
            i = page_index(p);
            return (i >= 0) ? page[i] : 8'd0;
        end
        case (p)
            P_STATUS0, P_STATUS1: begin
                c = (p == P_STATUS1);
                v = {8'd0, stat[c]};
                stat[c][3:0] = 4'd0;
                return v[7:0];
            end
            P_MCLR0, P_MCLR1, P_REQ1, P_SMASK1, P_MODE1, P_CLRFF1, P_CLRM1, P_WMASK1:
                return 8'd0;
            default: begin
                note_fault(FLT_PORT);
                return 8'd0;
            end
        endcase
    endfunction

    function automatic void write_port(input logic [7:0] p, input logic [7:0] v);
        int c, ch, i;
        bit is_cnt;
        if (decode_reg(p, c, ch, is_cnt)) begin
            i = c * 4 + ch;
            if (is_cnt) begin
                if (tgl[c]) begin b_cnt[i][15:8] = v; c_cnt[i][15:8] = v; end
                else begin b_cnt[i][7:0] = v; c_cnt[i][7:0] = v; end
            end else begin
                if (tgl[c]) begin b_addr[i][15:8] = v; c_addr[i][15:8] = v; end
                else begin b_addr[i][7:0] = v; c_addr[i][7:0] = v; end
            end
            tgl[c] = ~tgl[c];
            return;
        end
        if (p[7:4] == 4'h8 && p != P_PAGE_NONE) begin
            i = page_index(p);
            if (i >= 0) page[i] = v;
            return;
        end
        c = (p >= 8'hc0);
        ch = v[1:0];
        case (p)
            P_STATUS0, P_STATUS1: ;
            P_REQ0, P_REQ1: begin
                stat[c][4+ch] = v[2];
                refresh_out(c);
            end
            P_SMASK0, P_SMASK1: begin
                msk[c][ch] = v[2];
                refresh_out(c);
            end
            P_MODE0, P_MODE1: cmode[c*4+ch] = v[7:2];
            P_CLRFF0, P_CLRFF1: tgl[c] = 1'b0;
            P_MCLR0, P_MCLR1: begin
                msk[c] = 4'hf; stat[c] = 8'd0; tgl[c] = 1'b0;
            end
            P_CLRM0, P_CLRM1: begin
                msk[c] = 4'd0;
                refresh_out(c);
            end
            P_WMASK0, P_WMASK1: begin
                msk[c] = v[3:0];
                refresh_out(c);
            end
            default: note_fault(FLT_PORT);
        endcase
    endfunction

    function automatic void run_service(ref result_t r);
        int c, ch, i;
        bit tc;
        logic [23:0] phys;
        c = 1;
        ch = lowest_ready(1);
        tc = 0;
        if (ch == 0) begin c = 0; ch = lowest_ready(0); end
        if (ch >= 4) return;
        i = c * 4 + ch;
        phys = ({16'd0, page[i]} << 16) | ({8'd0, c_addr[i]} << c);
        if (cmode[i][3]) c_addr[i]--; else c_addr[i]++;
        c_cnt[i]--;
        if (c_cnt[i] == 16'hffff) begin
            stat[c][ch] = 1'b1;
            tc = 1;
            if (cmode[i][2]) begin
                c_addr[i] = b_addr[i]; c_cnt[i] = b_cnt[i];
            end else begin
                msk[c][ch] = 1'b1;
            end
        end
        case (cmode[i][1:0])
            2'd1: r.xfer_kind = KIND_WRITE;
            2'd2: r.xfer_kind = KIND_READ;
            2'd0: r.xfer_kind = KIND_VERIFY;
            default: note_fault(FLT_TTYPE3);
        endcase
        r.xfer_address = phys;
        r.xfer_channel = i[2:0];
        r.word_transfer = c[0];
        r.terminal_count = tc;
        if (tc) begin
            hold = 1'b0;
            if (c == 0) drive_line(4, 1'b0);
        end
    endfunction

    function automatic result_t predict_dma(input logic [1:0] md, input logic [7:0] p,
                                            input logic [15:0] d, input logic [2:0] sz,
                                            input logic [2:0] rch, input logic rlv);
        result_t r;
        r = '0;
        flt_now = FLT_OK;
        case (md)
            MODE_READ: begin
                if (sz != 3'd1) begin r.read_data = 8'hff; note_fault(FLT_WIDTH); end
                else r.read_data = read_port(p);
            end
            MODE_WRITE: begin
                if (sz == 3'd1) write_port(p, d[7:0]);
                else if (sz == 3'd2 && p == P_MODE0) begin
                    write_port(P_MODE0, d[7:0]);
                    write_port(P_CLRFF0, d[15:8]);
                end else note_fault(FLT_WIDTH);
            end
            MODE_REQ: drive_line(rch, rlv);
            default: run_service(r);
        endcase
        r.hold_request = hold;
        r.fault = flt_now;
        return r;
    endfunction

    task automatic init_model();
        for (int k = 0; k < 2; k++) begin
            tgl[k] = 0; stat[k] = 0; msk[k] = 4'hf;
        end
        for (int k = 0; k < 8; k++) begin
            b_addr[k] = 0; c_addr[k] = 0; b_cnt[k] = 0; c_cnt[k] = 0;
            page[k] = 0; cmode[k] = 0;
        end
        hold = 0;
    endtask

    // Send one request; burst gaps are inserted before it at random.
    int burst_left = 0;
    task automatic send_req(input logic [1:0] md, input logic [7:0] p,
                            input logic [15:0] d, input logic [2:0] sz,
                            input logic [2:0] rch = 3'd0, input logic rlv = 1'b0);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= {1'b0, rlv, rch, sz, d, p};
        pending_results.push_back(predict_dma(md, p, d, sz, rch, rlv));
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wr(input logic [7:0] p, input logic [7:0] v);
        send_req(MODE_WRITE, p, {8'd0, v}, 3'd1);
    endtask

    task automatic test_registers();
        wr(P_CLRFF0, 8'h00);
        wr(8'h00, 8'hff); wr(8'h00, 8'h00);
        wr(8'h01, 8'h34); wr(8'h01, 8'h12);
        wr(8'hc4, 8'hff); wr(8'hc4, 8'hff);
        wr(8'h87, 8'h5a); wr(8'h8b, 8'hff); wr(8'h84, 8'h11);
        send_req(MODE_READ, 8'h00, 16'd0, 3'd1);
        send_req(MODE_READ, 8'h00, 16'd0, 3'd1);
        send_req(MODE_READ, 8'h87, 16'd0, 3'd1);
        send_req(MODE_READ, 8'h8c, 16'd0, 3'd1);
        send_req(MODE_READ, 8'hd4, 16'd0, 3'd1);
        send_req(MODE_READ, 8'h55, 16'd0, 3'd1);
        send_req(MODE_READ, 8'h08, 16'd0, 3'd4);
        send_req(MODE_WRITE, 8'h08, 16'hffff, 3'd7);
        send_req(MODE_WRITE, P_MODE0, 16'hff58, 3'd2);
        wr(8'h60, 8'h00);
    endtask

    task automatic test_service();
        wr(P_MODE1, 8'hc0);          // channel 4 cascade-ish, verify
        wr(P_MODE0, 8'h19);          // channel 1 autoinit, read transfer, not block mode
        wr(P_CLRM0, 8'h00); wr(P_CLRM1, 8'h00);
        send_req(MODE_REQ, 8'd0, 16'd0, 3'd1, 3'd1, 1'b1);
        repeat (3) send_req(MODE_SVC, 8'd0, 16'd0, 3'd1);
        send_req(MODE_REQ, 8'd0, 16'd0, 3'd1, 3'd6, 1'b1);
        send_req(MODE_SVC, 8'd0, 16'd0, 3'd1);
        send_req(MODE_READ, P_STATUS0, 16'd0, 3'd1);
        send_req(MODE_READ, P_STATUS1, 16'd0, 3'd1);
        wr(P_WMASK1, 8'h0f); wr(P_MCLR0, 8'h00);
        send_req(MODE_SVC, 8'd0, 16'd0, 3'd1);
    endtask

    // Mostly meaningful ports, well-formed programming with random content.
    function automatic logic [7:0] pick_port();
        case ($urandom_range(0, 9))
            0, 1: return 8'($urandom_range(0, 15));
            2, 3: return 8'(8'hc0 + $urandom_range(0, 30));
            4: return 8'(8'h80 + $urandom_range(0, 15));
            5: return 8'($urandom_range(0, 255));
            default: return $urandom_range(0, 1) ? 8'($urandom_range(8, 15))
                                                 : 8'(8'hd0 + 2 * $urandom_range(0, 7));
        endcase
    endfunction

    task automatic test_random(input int n);
        logic [1:0] md;
        logic [2:0] sz;
        for (int k = 0; k < n; k++) begin
            md = 2'($urandom_range(0, 3));
            sz = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd1;
            if (md == MODE_WRITE && $urandom_range(0, 15) == 0) sz = 3'd2;
            send_req(md, pick_port(), 16'($urandom_range(0, 65535)), sz,
                     3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Receiver: random stalls plus one long hold-off window.
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        result_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '0;
            got.read_data = m_tdata[7:0];
            got.hold_request = m_tdata[8];
            got.xfer_address = m_tdata[32:9];
            got.xfer_channel = m_tdata[35:33];
            got.word_transfer = m_tdata[36];
            got.terminal_count = m_tdata[37];
            got.fault = m_tdata[40:38];
            got.xfer_kind = m_tuser;
            if (pending_results.size() == 0) begin
                report("unexpected result", m_tdata[31:0], 0);
            end else begin
                want = pending_results.pop_front();
                if (got.read_data != want.read_data) report("read_data", got.read_data, want.read_data);
                if (got.hold_request != want.hold_request)
                    report("hold_request", got.hold_request, want.hold_request);
                if (got.xfer_kind != want.xfer_kind) report("xfer_kind", got.xfer_kind, want.xfer_kind);
                if (got.xfer_address != want.xfer_address)
                    report("xfer_address", got.xfer_address, want.xfer_address);
                if (got.xfer_channel != want.xfer_channel)
                    report("xfer_channel", got.xfer_channel, want.xfer_channel);
                if (got.word_transfer != want.word_transfer)
                    report("word_transfer", got.word_transfer, want.word_transfer);
                if (got.terminal_count != want.terminal_count)
                    report("terminal_count", got.terminal_count, want.terminal_count);
                if (got.fault != want.fault) report("fault", got.fault, want.fault);
            end
        end
    end

    initial begin
        init_model();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_registers();
        test_service();
        hold_off = 60;   // stall the result side so the queue fills
        test_random(450);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (error_count == 0) $display("dual_dma_controller test passed");
        else $display("dual_dma_controller test failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("dual_dma_controller test failed");
        $finish;
    end

endmodule

### files.f
rtl/core/ddc_pkg.sv
rtl/core/ddc_front.sv
rtl/core/ddc_queue.sv
rtl/core/ddc_back.sv
rtl/core/dual_dma_controller.sv
tb/testbench.sv
